// ===== rtl/topic_subscription_table_aging_assert.svh =====
// Assertion macros used by the topic table top level.
`ifndef TOPIC_SUBSCRIPTION_TABLE_AGING_ASSERT_SVH
`define TOPIC_SUBSCRIPTION_TABLE_AGING_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while in reset.
`define TSTA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("topic table check failed");

// Next-cycle implication, sampled on clk and disabled while in reset.
`define TSTA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("topic table check failed");

`endif

// ===== rtl/tsta_pkg.sv =====
// Types and constants of the topic subscription table.
package tsta_pkg;

    typedef enum logic [1:0] {
        OP_SUBSCRIBE = 2'd0,
        OP_PUBLISH   = 2'd1,
        OP_HEARTBEAT = 2'd2,
        OP_TICK      = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_FORWARD    = 3'd0,
        KIND_DROPPED    = 3'd1,
        KIND_SUBSCRIBED = 3'd2,
        KIND_FULL       = 3'd3,
        KIND_HEARTBEAT  = 3'd4,
        KIND_EXPIRED    = 3'd5,
        KIND_TICK       = 3'd6,
        KIND_SHORT      = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_EXEC,
        ST_FAN_RD,
        ST_FAN,
        ST_SWEEP_CHK,
        ST_SWEEP,
        ST_FLUSH
    } state_t;

    localparam logic [1:0] REG_EXPIRE_AGE   = 2'd0;
    localparam logic [1:0] REG_SWEEP_PERIOD = 2'd1;
    localparam logic [1:0] REG_MIN_LENGTH   = 2'd2;

    localparam logic [15:0] EXPIRE_AGE_RESET   = 16'd15;
    localparam logic [15:0] SWEEP_PERIOD_RESET = 16'd10;
    localparam logic [10:0] MIN_LENGTH_RESET   = 11'd12;

    typedef struct packed {
        logic [15:0] expire_age;
        logic [15:0] sweep_period;
        logic [10:0] min_length;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] out_topic;
        logic [31:0] dest_addr;
        logic [15:0] dest_port;
        logic [7:0]  out_tag;
        logic [10:0] out_length;
        logic [4:0]  subscriber_count;
    } result_t;

endpackage

// ===== rtl/tsta_if.sv =====
// Request and result channel interfaces of the topic table.
interface tsta_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] topic;
    logic [31:0] sender_addr;
    logic [15:0] client_port;
    logic [7:0]  packet_tag;
    logic [10:0] packet_length;

    modport source (output valid, operation, topic, sender_addr, client_port,
                    packet_tag, packet_length, input ready);
    modport sink (input valid, operation, topic, sender_addr, client_port,
                  packet_tag, packet_length, output ready);
endinterface

interface tsta_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] out_topic;
    logic [31:0] dest_addr;
    logic [15:0] dest_port;
    logic [7:0]  out_tag;
    logic [10:0] out_length;
    logic [4:0]  subscriber_count;
    logic        last;

    modport source (output valid, kind, out_topic, dest_addr, dest_port, out_tag,
                    out_length, subscriber_count, last, input ready);
    modport sink (input valid, kind, out_topic, dest_addr, dest_port, out_tag,
                  out_length, subscriber_count, last, output ready);
endinterface

// ===== rtl/tsta_sub_mem.sv =====
// Subscriber store: one write port, one registered read port.
module tsta_sub_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [47:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [47:0]   rdata
);

    logic [47:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/tsta_cfg.sv =====
// Configuration registers behind the APB-style port.
module tsta_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output tsta_pkg::cfg_t     cfg
);

    tsta_pkg::cfg_t cfg_reg;
    logic           wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expire_age   <= tsta_pkg::EXPIRE_AGE_RESET;
            cfg_reg.sweep_period <= tsta_pkg::SWEEP_PERIOD_RESET;
            cfg_reg.min_length   <= tsta_pkg::MIN_LENGTH_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                tsta_pkg::REG_EXPIRE_AGE:   cfg_reg.expire_age   <= pwdata[15:0];
                tsta_pkg::REG_SWEEP_PERIOD: cfg_reg.sweep_period <= pwdata[15:0];
                tsta_pkg::REG_MIN_LENGTH:   cfg_reg.min_length   <= pwdata[10:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            tsta_pkg::REG_EXPIRE_AGE:   prdata = {16'd0, cfg_reg.expire_age};
            tsta_pkg::REG_SWEEP_PERIOD: prdata = {16'd0, cfg_reg.sweep_period};
            tsta_pkg::REG_MIN_LENGTH:   prdata = {21'd0, cfg_reg.min_length};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/topic_subscription_table_aging.sv =====
// Top level of the topic subscription table with aging.
// The block keeps up to MAX_TOPICS topics, each with up to MAX_SUBSCRIBERS
// subscribers, and handles one request at a time under a small sequencer.
// A subscribe, publish or heartbeat request first scans the entry table,
// one entry per cycle, then the exec state acts on it and may update the
// table for a subscribe or heartbeat. A publish then reads the subscriber
// store once per subscriber, with a store read state and a fan state for
// each forward result. After every request but a short one, when the sweep
// period has run out, a further pass over all entries checks every entry's
// age against a single shared subtract and compare and reports expired
// topics. A tick skips the scan, and a short message goes straight to the
// flush. Results are held one deep before the output register so that the
// last flag can be set on the final result of each request; the request
// side is ready only while the sequencer is idle.
module topic_subscription_table_aging #(
    parameter int MAX_TOPICS      = 16,
    parameter int MAX_SUBSCRIBERS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    tsta_req_if.sink      req,
    tsta_rsp_if.source    rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int TW    = (MAX_TOPICS > 1) ? $clog2(MAX_TOPICS) : 1;
    localparam int CW    = $clog2(MAX_SUBSCRIBERS + 1);
    localparam int DEPTH = MAX_TOPICS * MAX_SUBSCRIBERS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    tsta_pkg::cfg_t cfg;

    tsta_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Entry table.
    logic [MAX_TOPICS-1:0] valid_reg;
    logic [15:0]           topic_mem [MAX_TOPICS];
    logic [CW-1:0]         count_mem [MAX_TOPICS];
    logic [31:0]           active_mem [MAX_TOPICS];

    // Sequencer and request latch.
    tsta_pkg::state_t state_reg, state_next;
    logic [1:0]       op_reg;
    logic [15:0]      topic_reg;
    logic [47:0]      client_reg;
    logic [7:0]       tag_reg;
    logic [10:0]      len_reg;
    logic [TW-1:0]    idx_reg, idx_next;
    logic [TW-1:0]    ent_reg, ent_next;
    logic             found_reg, found_next;
    logic             free_reg, free_next;
    logic [CW-1:0]    k_reg, k_next;
    logic [31:0]      seconds_reg, seconds_next;
    logic [31:0]      sweep_at_reg, sweep_at_next;

    // Result staging: one pending result and the output register.
    tsta_pkg::result_t pend_reg;
    logic              pend_valid_reg;
    tsta_pkg::result_t out_reg;
    logic              out_valid_reg;
    logic              out_last_reg;

    logic              accept;
    logic              slot_free;
    logic              can_push;
    logic              push;
    logic              flush;
    tsta_pkg::result_t push_data;

    // Table write controls.
    logic [TW-1:0] rd_idx;
    logic          set_valid, clr_valid, wr_topic, wr_count, wr_active;
    logic [CW-1:0] count_wdata;
    logic [15:0]   rd_topic;
    logic [CW-1:0] rd_count;
    logic [31:0]   rd_active;
    logic          last_entry;

    logic          mem_we;
    logic [AW-1:0] mem_base;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [47:0]   mem_rdata;

    tsta_sub_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_sub_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (client_reg),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign accept     = req.valid && req.ready;
    assign req.ready  = (state_reg == tsta_pkg::ST_IDLE);
    assign slot_free  = !out_valid_reg || rsp.ready;
    assign can_push   = !pend_valid_reg || slot_free;

    // The table is read at one index: the scan index while walking, else the
    // entry chosen by the lookup.
    assign rd_idx     = (state_reg == tsta_pkg::ST_LOOK || state_reg == tsta_pkg::ST_SWEEP)
                        ? idx_reg : ent_reg;
    assign rd_topic   = topic_mem[rd_idx];
    assign rd_count   = count_mem[rd_idx];
    assign rd_active  = active_mem[rd_idx];
    assign last_entry = (idx_reg == TW'(MAX_TOPICS - 1));

    assign mem_base   = AW'(ent_reg) * AW'(MAX_SUBSCRIBERS);
    assign mem_waddr  = mem_base + AW'(found_reg ? rd_count : {CW{1'b0}});
    assign mem_raddr  = mem_base + AW'(k_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tsta_pkg::ST_IDLE;
            idx_reg     <= '0;
            ent_reg     <= '0;
            found_reg   <= 1'b0;
            free_reg    <= 1'b0;
            k_reg       <= '0;
            seconds_reg <= '0;
            sweep_at_reg <= '0;
            valid_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            ent_reg      <= ent_next;
            found_reg    <= found_next;
            free_reg     <= free_next;
            k_reg        <= k_next;
            seconds_reg  <= seconds_next;
            sweep_at_reg <= sweep_at_next;
            if (set_valid)
            begin
                valid_reg[rd_idx] <= 1'b1;
            end
            if (clr_valid)
            begin
                valid_reg[rd_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= req.operation;
            topic_reg  <= req.topic;
            client_reg <= {req.sender_addr, req.client_port};
            tag_reg    <= req.packet_tag;
            len_reg    <= req.packet_length;
        end
        if (wr_topic)
        begin
            topic_mem[rd_idx] <= topic_reg;
        end
        if (wr_count)
        begin
            count_mem[rd_idx] <= count_wdata;
        end
        if (wr_active)
        begin
            active_mem[rd_idx] <= seconds_reg;
        end
    end

    // Result staging. A new result moves the pending one to the output;
    // the final one leaves with the last flag on flush.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                pend_valid_reg <= 1'b1;
                if (pend_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                    out_last_reg  <= 1'b0;
                end
                else if (out_valid_reg && rsp.ready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
            else if (flush)
            begin
                pend_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
                out_last_reg   <= 1'b1;
            end
            else if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            pend_reg <= push_data;
            if (pend_valid_reg)
            begin
                out_reg <= pend_reg;
            end
        end
        else if (flush)
        begin
            out_reg <= pend_reg;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.kind             = out_reg.kind;
    assign rsp.out_topic        = out_reg.out_topic;
    assign rsp.dest_addr        = out_reg.dest_addr;
    assign rsp.dest_port        = out_reg.dest_port;
    assign rsp.out_tag          = out_reg.out_tag;
    assign rsp.out_length       = out_reg.out_length;
    assign rsp.subscriber_count = out_reg.subscriber_count;
    assign rsp.last             = out_last_reg;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        ent_next      = ent_reg;
        found_next    = found_reg;
        free_next     = free_reg;
        k_next        = k_reg;
        seconds_next  = seconds_reg;
        sweep_at_next = sweep_at_reg;
        push          = 1'b0;
        flush         = 1'b0;
        push_data     = '0;
        push_data.out_topic = topic_reg;
        set_valid     = 1'b0;
        clr_valid     = 1'b0;
        wr_topic      = 1'b0;
        wr_count      = 1'b0;
        wr_active     = 1'b0;
        count_wdata   = rd_count;
        mem_we        = 1'b0;

        case (state_reg)
            tsta_pkg::ST_IDLE:
            begin
                idx_next   = '0;
                found_next = 1'b0;
                free_next  = 1'b0;
                k_next     = '0;
                if (accept)
                begin
                    if (req.operation == tsta_pkg::OP_TICK)
                    begin
                        seconds_next   = seconds_reg + 32'd1;
                        push           = 1'b1;
                        push_data.kind = tsta_pkg::KIND_TICK;
                        push_data.out_topic = '0;
                        state_next     = tsta_pkg::ST_SWEEP_CHK;
                    end
                    else if (req.packet_length < cfg.min_length)
                    begin
                        push           = 1'b1;
                        push_data.kind = tsta_pkg::KIND_SHORT;
                        push_data.out_topic = req.topic;
                        state_next     = tsta_pkg::ST_FLUSH;
                    end
                    else
                    begin
                        state_next = tsta_pkg::ST_LOOK;
                    end
                end
            end

            tsta_pkg::ST_LOOK:
            begin
                // Lowest matching valid entry and lowest free entry.
                if (valid_reg[idx_reg] && rd_topic == topic_reg && !found_reg)
                begin
                    found_next = 1'b1;
                    ent_next   = idx_reg;
                end
                else if (!valid_reg[idx_reg] && !free_reg && !found_reg)
                begin
                    free_next = 1'b1;
                    ent_next  = idx_reg;
                end
                idx_next = idx_reg + TW'(1);
                if (last_entry)
                begin
                    idx_next   = '0;
                    state_next = tsta_pkg::ST_EXEC;
                end
            end

            tsta_pkg::ST_EXEC:
            begin
                state_next = tsta_pkg::ST_SWEEP_CHK;
                push       = 1'b1;
                case (op_reg)
                    tsta_pkg::OP_SUBSCRIBE:
                    begin
                        if (found_reg && rd_count < CW'(MAX_SUBSCRIBERS))
                        begin
                            mem_we      = 1'b1;
                            wr_count    = 1'b1;
                            count_wdata = rd_count + CW'(1);
                            wr_active   = 1'b1;
                            push_data.kind = tsta_pkg::KIND_SUBSCRIBED;
                            push_data.subscriber_count = 5'(count_wdata);
                        end
                        else if (!found_reg && free_reg)
                        begin
                            set_valid   = 1'b1;
                            wr_topic    = 1'b1;
                            mem_we      = 1'b1;
                            wr_count    = 1'b1;
                            count_wdata = CW'(1);
                            wr_active   = 1'b1;
                            push_data.kind = tsta_pkg::KIND_SUBSCRIBED;
                            push_data.subscriber_count = 5'(count_wdata);
                        end
                        else
                        begin
                            push_data.kind = tsta_pkg::KIND_FULL;
                            push_data.subscriber_count =
                                found_reg ? 5'(rd_count) : 5'd0;
                        end
                    end
                    tsta_pkg::OP_PUBLISH:
                    begin
                        if (found_reg && rd_count != '0)
                        begin
                            push       = 1'b0;
                            state_next = tsta_pkg::ST_FAN_RD;
                        end
                        else
                        begin
                            push_data.kind = tsta_pkg::KIND_DROPPED;
                        end
                    end
                    default:
                    begin
                        wr_active = found_reg;
                        push_data.kind = tsta_pkg::KIND_HEARTBEAT;
                        push_data.subscriber_count = found_reg ? 5'(rd_count) : 5'd0;
                    end
                endcase
            end

            tsta_pkg::ST_FAN_RD:
            begin
                // The store read for subscriber k lands next cycle.
                state_next = tsta_pkg::ST_FAN;
            end

            tsta_pkg::ST_FAN:
            begin
                push_data.kind       = tsta_pkg::KIND_FORWARD;
                push_data.dest_addr  = mem_rdata[47:16];
                push_data.dest_port  = mem_rdata[15:0];
                push_data.out_tag    = tag_reg;
                push_data.out_length = len_reg;
                push_data.subscriber_count = 5'(rd_count);
                if (can_push)
                begin
                    push   = 1'b1;
                    k_next = k_reg + CW'(1);
                    if (k_next == rd_count)
                    begin
                        wr_active  = 1'b1;
                        state_next = tsta_pkg::ST_SWEEP_CHK;
                    end
                    else
                    begin
                        state_next = tsta_pkg::ST_FAN_RD;
                    end
                end
            end

            tsta_pkg::ST_SWEEP_CHK:
            begin
                idx_next = '0;
                if ((seconds_reg - sweep_at_reg) > {16'd0, cfg.sweep_period})
                begin
                    state_next = tsta_pkg::ST_SWEEP;
                end
                else
                begin
                    state_next = tsta_pkg::ST_FLUSH;
                end
            end

            tsta_pkg::ST_SWEEP:
            begin
                push_data.kind      = tsta_pkg::KIND_EXPIRED;
                push_data.out_topic = rd_topic;
                if (valid_reg[idx_reg] &&
                    (seconds_reg - rd_active) > {16'd0, cfg.expire_age})
                begin
                    if (can_push)
                    begin
                        push      = 1'b1;
                        clr_valid = 1'b1;
                    end
                end
                if (can_push)
                begin
                    idx_next = idx_reg + TW'(1);
                    if (last_entry)
                    begin
                        idx_next      = '0;
                        sweep_at_next = seconds_reg;
                        state_next    = tsta_pkg::ST_FLUSH;
                    end
                end
            end

            tsta_pkg::ST_FLUSH:
            begin
                if (slot_free)
                begin
                    flush      = 1'b1;
                    state_next = tsta_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tsta_pkg::ST_IDLE;
            end
        endcase
    end

`include "topic_subscription_table_aging_assert.svh"

    // A request is taken only with no result left over from the one before.
    `TSTA_ASSERT_NOW(a_idle_no_pending, req.ready, !pend_valid_reg)
    // The sequencer is busy in the cycle after it takes a request.
    `TSTA_ASSERT_NEXT(a_busy_after_accept, accept, !req.ready)
    // The seconds counter moves only on an accepted tick.
    `TSTA_ASSERT_NEXT(a_seconds_on_tick,
        !(accept && req.operation == tsta_pkg::OP_TICK), $stable(seconds_reg))
    // A flush always finds a pending result to send.
    `TSTA_ASSERT_NOW(a_flush_has_result, flush, pend_valid_reg)

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the topic subscription table with aging.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_TOPICS      = 16;
    localparam int NUM_SUBSCRIBERS = 16;
    localparam int LONG_STALL      = 400;
    localparam int IDLE_LIMIT      = 20000;
    localparam int DRAIN_CYCLES    = 200;

    // One request as the sender offers it.
    typedef struct {
        tsta_pkg::op_t op;
        logic [15:0]   topic;
        logic [31:0]   addr;
        logic [15:0]   port;
        logic [7:0]    tag;
        logic [10:0]   len;
    } request_t;

    // One result with its end-of-request flag.
    typedef struct {
        tsta_pkg::result_t res;
        logic              last;
    } outcome_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    tsta_req_if req ();
    tsta_rsp_if rsp ();

    topic_subscription_table_aging dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req.sink),
        .rsp     (rsp.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Requests waiting to be offered, and results the table is expected to produce.
    request_t pending_requests[$];
    outcome_t expected_outcomes[$];
    request_t offered;

    // Shadow of the table that the testbench keeps itself.
    logic [15:0] age_limit;
    logic [15:0] sweep_gap;
    logic [10:0] shortest_len;
    bit          slot_used[NUM_TOPICS];
    logic [15:0] slot_topic[NUM_TOPICS];
    logic [4:0]  slot_count[NUM_TOPICS];
    logic [31:0] slot_active[NUM_TOPICS];
    logic [47:0] slot_members[NUM_TOPICS][NUM_SUBSCRIBERS];
    logic [31:0] clock_secs;
    logic [31:0] last_sweep_secs;

    // Pressure and idling controls, written with nonblocking assignments once set up.
    logic quiet;
    int   stall_requests;
    int   stalls_served;
    int   stall_left;

    int errors;
    int requests_sent;
    int results_checked;
    int kind_seen[8];
    int idle_cycles;
    logic [15:0] topic_pool[20];

    always #5 clk = ~clk;

    function automatic outcome_t make_outcome(tsta_pkg::kind_t k, logic [15:0] t,
                                              logic [31:0] a, logic [15:0] p,
                                              logic [7:0] g, logic [10:0] l,
                                              logic [4:0] c);
        outcome_t o;
        o.res.kind = k;
        o.res.out_topic = t;
        o.res.dest_addr = a;
        o.res.dest_port = p;
        o.res.out_tag = g;
        o.res.out_length = l;
        o.res.subscriber_count = c;
        o.last = 1'b0;
        return o;
    endfunction

    // Works out every result one accepted request causes and queues them in order.
    task automatic predict_request(input request_t rq);
        outcome_t batch[$];
        outcome_t o;
        int hit;
        int slot;
        logic [31:0] since;
        if (rq.op != tsta_pkg::OP_TICK && rq.len < shortest_len)
        begin
            o = make_outcome(tsta_pkg::KIND_SHORT, rq.topic, '0, '0, '0, '0, '0);
            o.last = 1'b1;
            expected_outcomes.insert(expected_outcomes.size(), o);
            return;
        end
        hit = -1;
        for (int i = 0; i < NUM_TOPICS; i++)
            if (hit < 0 && slot_used[i] && slot_topic[i] == rq.topic)
                hit = i;
        case (rq.op)
            tsta_pkg::OP_SUBSCRIBE:
            begin
                if (hit < 0)
                begin
                    slot = -1;
                    for (int i = 0; i < NUM_TOPICS; i++)
                        if (slot < 0 && !slot_used[i])
                            slot = i;
                    if (slot >= 0)
                    begin
                        slot_used[slot] = 1'b1;
                        slot_topic[slot] = rq.topic;
                        slot_count[slot] = '0;
                        hit = slot;
                    end
                end
                if (hit < 0 || slot_count[hit] >= NUM_SUBSCRIBERS)
                begin
                    batch.insert(batch.size(),
                                 make_outcome(tsta_pkg::KIND_FULL, rq.topic, '0, '0, '0, '0,
                                              hit < 0 ? 5'd0 : slot_count[hit]));
                end
                else
                begin
                    slot_members[hit][slot_count[hit]] = {rq.addr, rq.port};
                    slot_count[hit] = slot_count[hit] + 5'd1;
                    slot_active[hit] = clock_secs;
                    batch.insert(batch.size(),
                                 make_outcome(tsta_pkg::KIND_SUBSCRIBED, rq.topic, '0, '0,
                                              '0, '0, slot_count[hit]));
                end
            end
            tsta_pkg::OP_PUBLISH:
            begin
                if (hit < 0 || slot_count[hit] == 0)
                begin
                    batch.insert(batch.size(),
                                 make_outcome(tsta_pkg::KIND_DROPPED, rq.topic, '0, '0, '0,
                                              '0, '0));
                end
                else
                begin
                    for (int k = 0; k < slot_count[hit]; k++)
                        batch.insert(batch.size(),
                                     make_outcome(tsta_pkg::KIND_FORWARD, rq.topic,
                                                  slot_members[hit][k][47:16],
                                                  slot_members[hit][k][15:0],
                                                  rq.tag, rq.len, slot_count[hit]));
                    slot_active[hit] = clock_secs;
                end
            end
            tsta_pkg::OP_HEARTBEAT:
            begin
                if (hit >= 0)
                    slot_active[hit] = clock_secs;
                batch.insert(batch.size(),
                             make_outcome(tsta_pkg::KIND_HEARTBEAT, rq.topic, '0, '0, '0, '0,
                                          hit < 0 ? 5'd0 : slot_count[hit]));
            end
            default:
            begin
                clock_secs = clock_secs + 32'd1;
                batch.insert(batch.size(),
                             make_outcome(tsta_pkg::KIND_TICK, '0, '0, '0, '0, '0, '0));
            end
        endcase
        // Ages are taken modulo 2^32, so the subtractions stay in 32 bits.
        since = clock_secs - last_sweep_secs;
        if (since > {16'd0, sweep_gap})
        begin
            for (int i = 0; i < NUM_TOPICS; i++)
            begin
                since = clock_secs - slot_active[i];
                if (slot_used[i] && since > {16'd0, age_limit})
                begin
                    slot_used[i] = 1'b0;
                    batch.insert(batch.size(),
                                 make_outcome(tsta_pkg::KIND_EXPIRED, slot_topic[i], '0, '0,
                                              '0, '0, '0));
                end
            end
            last_sweep_secs = clock_secs;
        end
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            expected_outcomes.insert(expected_outcomes.size(), batch[i]);
    endtask

    // Request driver: holds an offered request until it is taken, then picks the next.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                predict_request(offered);
                requests_sent++;
            end
            if (req.valid && !req.ready)
            begin
                // The request stays on the bus until the table takes it.
            end
            else if (pending_requests.size() > 0 &&
                     (quiet || $urandom_range(99) >= 15))
            begin
                offered = pending_requests.pop_front();
                req.operation <= offered.op;
                req.topic <= offered.topic;
                req.sender_addr <= offered.addr;
                req.client_port <= offered.port;
                req.packet_tag <= offered.tag;
                req.packet_length <= offered.len;
                req.valid <= 1'b1;
            end
            else
            begin
                req.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random back-pressure, plus a long hold-off whenever one is asked for.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            stall_left <= 0;
            stalls_served <= 0;
        end
        else if (stalls_served != stall_requests)
        begin
            stalls_served <= stalls_served + 1;
            stall_left <= LONG_STALL;
            rsp.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp.ready <= 1'b0;
        end
        else
        begin
            rsp.ready <= quiet || ($urandom_range(99) >= 15);
        end
    end

    // Result monitor: every accepted result must match the oldest expectation.
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            results_checked++;
            kind_seen[rsp.kind]++;
            if (expected_outcomes.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] unexpected result kind=%0d topic=%h", $realtime,
                             rsp.kind, rsp.out_topic);
            end
            else
            begin
                want = expected_outcomes.pop_front();
                if (rsp.kind !== want.res.kind || rsp.out_topic !== want.res.out_topic ||
                    rsp.dest_addr !== want.res.dest_addr ||
                    rsp.dest_port !== want.res.dest_port ||
                    rsp.out_tag !== want.res.out_tag ||
                    rsp.out_length !== want.res.out_length ||
                    rsp.subscriber_count !== want.res.subscriber_count ||
                    rsp.last !== want.last)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display({"[%0t] mismatch: expected kind=%0d topic=%h addr=%h",
                                  " port=%h tag=%h len=%0d cnt=%0d last=%b"},
                                 $realtime, want.res.kind, want.res.out_topic,
                                 want.res.dest_addr, want.res.dest_port, want.res.out_tag,
                                 want.res.out_length, want.res.subscriber_count, want.last);
                        $display({"[%0t]           actual kind=%0d topic=%h addr=%h",
                                  " port=%h tag=%h len=%0d cnt=%0d last=%b"},
                                 $realtime, rsp.kind, rsp.out_topic, rsp.dest_addr,
                                 rsp.dest_port, rsp.out_tag, rsp.out_length,
                                 rsp.subscriber_count, rsp.last);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any request or result moving means the table hung.
    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic queue_request(tsta_pkg::op_t op, logic [15:0] t, logic [31:0] a,
                                 logic [15:0] p, logic [7:0] g, logic [10:0] l);
        request_t rq;
        rq.op = op;
        rq.topic = t;
        rq.addr = a;
        rq.port = p;
        rq.tag = g;
        rq.len = l;
        pending_requests.insert(pending_requests.size(), rq);
    endtask

    // Lets the table drain completely, including any trailing sweep, before moving on.
    task automatic wait_drained();
        while (pending_requests.size() > 0 || req.valid || expected_outcomes.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // Register write over the configuration port: a setup phase, then an access phase.
    task automatic write_register(logic [1:0] index, logic [15:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            tsta_pkg::REG_EXPIRE_AGE:   age_limit = value;
            tsta_pkg::REG_SWEEP_PERIOD: sweep_gap = value;
            tsta_pkg::REG_MIN_LENGTH:   shortest_len = value[10:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [15:0] age, logic [15:0] gap, logic [10:0] min_len);
        wait_drained();
        write_register(tsta_pkg::REG_EXPIRE_AGE, age);
        write_register(tsta_pkg::REG_SWEEP_PERIOD, gap);
        write_register(tsta_pkg::REG_MIN_LENGTH, {5'd0, min_len});
    endtask

    function automatic logic [10:0] good_length();
        if ($urandom_range(9) == 0)
            return 11'd1024;
        return 11'($urandom_range(1024, shortest_len));
    endfunction

    // Random traffic built mostly from meaningful sequences on a small topic pool, so
    // that lists fill, the table fills, and topics age out; the rest is noise.
    task automatic queue_random(int count);
        int made;
        int pick;
        int burst;
        logic [15:0] t;
        made = 0;
        foreach (topic_pool[i])
            topic_pool[i] = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'($urandom);
        while (made < count)
        begin
            pick = $urandom_range(99);
            t = topic_pool[$urandom_range(19)];
            if (pick < 40)
            begin
                // A run of subscribers, sometimes past the list limit, then a publish.
                burst = ($urandom_range(7) == 0) ? 18 : $urandom_range(1, 5);
                for (int i = 0; i < burst; i++)
                    queue_request(tsta_pkg::OP_SUBSCRIBE, t, $urandom, 16'($urandom),
                                  8'($urandom), good_length());
                queue_request(tsta_pkg::OP_PUBLISH, t, $urandom, 16'($urandom),
                              8'($urandom), good_length());
                made += burst + 1;
            end
            else if (pick < 60)
            begin
                burst = $urandom_range(1, 4);
                for (int i = 0; i < burst; i++)
                    queue_request(tsta_pkg::OP_TICK, 16'($urandom), $urandom, 16'($urandom),
                                  8'($urandom), 11'($urandom_range(1024)));
                made += burst;
            end
            else if (pick < 75)
            begin
                queue_request(tsta_pkg::OP_HEARTBEAT, t, $urandom, 16'($urandom),
                              8'($urandom), good_length());
                made++;
            end
            else if (pick < 85)
            begin
                queue_request(tsta_pkg::OP_PUBLISH, t, $urandom, 16'($urandom),
                              8'($urandom), good_length());
                made++;
            end
            else if (pick < 95)
            begin
                queue_request(tsta_pkg::op_t'($urandom_range(3)), 16'($urandom), $urandom,
                              16'($urandom), 8'($urandom), 11'($urandom_range(1024)));
                made++;
            end
            else if (shortest_len > 0)
            begin
                // Too short to be looked at; it does not count toward the total.
                queue_request(tsta_pkg::op_t'($urandom_range(2)), t, $urandom,
                              16'($urandom), 8'($urandom),
                              11'($urandom_range(shortest_len - 1)));
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req.valid = 1'b0;
        req.operation = '0;
        req.topic = '0;
        req.sender_addr = '0;
        req.client_port = '0;
        req.packet_tag = '0;
        req.packet_length = '0;
        rsp.ready = 1'b0;
        quiet = 1'b0;
        stall_requests = 0;
        errors = 0;
        requests_sent = 0;
        results_checked = 0;
        idle_cycles = 0;
        foreach (kind_seen[i])
            kind_seen[i] = 0;
        age_limit = tsta_pkg::EXPIRE_AGE_RESET;
        sweep_gap = tsta_pkg::SWEEP_PERIOD_RESET;
        shortest_len = tsta_pkg::MIN_LENGTH_RESET;
        foreach (slot_used[i])
            slot_used[i] = 1'b0;
        clock_secs = '0;
        last_sweep_secs = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part under the reset settings: field extremes, every operation,
        // short messages at the length boundary, unknown topics, then ticks up to
        // and past the first sweep.
        queue_request(tsta_pkg::OP_SUBSCRIBE, 16'h0000, 32'h0, 16'h0, 8'h00, 11'd12);
        queue_request(tsta_pkg::OP_SUBSCRIBE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF,
                      11'd1024);
        queue_request(tsta_pkg::OP_SUBSCRIBE, 16'hFFFF, 32'hA5A5_5A5A, 16'h5A5A, 8'h00,
                      11'd700);
        queue_request(tsta_pkg::OP_PUBLISH, 16'hFFFF, 32'h0, 16'h0, 8'hFF, 11'd1024);
        queue_request(tsta_pkg::OP_PUBLISH, 16'h0000, 32'hFFFF_FFFF, 16'hFFFF, 8'h00,
                      11'd12);
        queue_request(tsta_pkg::OP_PUBLISH, 16'h1234, 32'h0, 16'h0, 8'h5A, 11'd100);
        queue_request(tsta_pkg::OP_HEARTBEAT, 16'h0000, 32'h0, 16'h0, 8'h0, 11'd20);
        queue_request(tsta_pkg::OP_HEARTBEAT, 16'h4321, 32'h0, 16'h0, 8'h0, 11'd20);
        queue_request(tsta_pkg::OP_SUBSCRIBE, 16'h0777, 32'h1, 16'h1, 8'h1, 11'd11);
        queue_request(tsta_pkg::OP_PUBLISH, 16'hFFFF, 32'h0, 16'h0, 8'hFF, 11'd0);
        queue_request(tsta_pkg::OP_HEARTBEAT, 16'hFFFF, 32'h0, 16'h0, 8'h0, 11'd5);
        queue_request(tsta_pkg::OP_TICK, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 11'd0);
        for (int i = 0; i < 11; i++)
            queue_request(tsta_pkg::OP_TICK, 16'h0, 32'h0, 16'h0, 8'h0, 11'd2047);
        wait_drained();

        // Fast aging, no length limit; a long result hold-off lets the table back up.
        configure(16'd1, 16'd1, 11'd0);
        queue_random(60);
        stall_requests <= stall_requests + 1;
        wait_drained();

        // Nothing ever ages out and only full-size messages pass; the table fills.
        // This phase runs with no idling on either side.
        configure(16'hFFFF, 16'hFFFF, 11'd1024);
        quiet <= 1'b1;
        queue_random(50);
        wait_drained();
        quiet <= 1'b0;

        // Moderate aging with a sender pause halfway and another long hold-off.
        configure(16'd4, 16'd2, 11'd12);
        queue_random(45);
        wait_drained();
        queue_random(45);
        stall_requests <= stall_requests + 1;
        wait_drained();

        configure(16'd6, 16'd3, 11'd100);
        queue_random(60);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests and checked %0d results: %0d forwards, %0d expiries,",
                 requests_sent, results_checked, kind_seen[tsta_pkg::KIND_FORWARD],
                 kind_seen[tsta_pkg::KIND_EXPIRED]);
        $display("%0d table-full, %0d short, over five register settings.",
                 kind_seen[tsta_pkg::KIND_FULL], kind_seen[tsta_pkg::KIND_SHORT]);
        if (errors == 0 && expected_outcomes.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/tsta_pkg.sv
rtl/tsta_if.sv
rtl/tsta_sub_mem.sv
rtl/tsta_cfg.sv
rtl/topic_subscription_table_aging.sv
tb/sv/tb.sv
